>>> rtl/ntm_pkg.sv
// Shared types and constants for the nearest timestamp match block.
// Used by every module of the block but ntm_ram; depends on nothing.
`default_nettype none

package ntm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int STAMP_W     = 63;
    localparam int INDEX_W     = 10;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } back_state_t;

    typedef struct packed {
        cmd_t                 command;
        logic [STAMP_W-1:0]   stamp;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]   match_index;
        logic [STAMP_W-1:0]   match_stamp;
        logic [STAMP_W-1:0]   match_distance;
        logic                 overflow;
    } out_item_t;

endpackage

`default_nettype wire

>>> rtl/ntm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module ntm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/ntm_front.sv
// Front end: accepts command beats, drops unused codes, and queues the rest
// for the back end. Depends on ntm_pkg.
`default_nettype none

module ntm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ntm_pkg::in_item_t in_item,
    output logic                   q_valid,
    output ntm_pkg::in_item_t      q_item,
    input  wire logic              q_pop
);

    ntm_pkg::in_item_t                   slot_reg [ntm_pkg::QUEUE_DEPTH];
    logic [ntm_pkg::QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [ntm_pkg::QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [ntm_pkg::QCOUNT_W-1:0]        count_reg, count_next;
    logic                                accept;
    logic                                enq;
    logic                                deq;

    assign full    = (count_reg == ntm_pkg::QCOUNT_W'(ntm_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    assign accept = push && !full;
    // drop command codes that do nothing
    assign enq    = accept && (in_item.command != ntm_pkg::CMD_NOP);
    assign deq    = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!enq && deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ntm_back.sv
// Back end: executes clear, append and query commands against the target
// table and holds one result. Depends on ntm_pkg and ntm_ram.
`default_nettype none

module ntm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire ntm_pkg::in_item_t q_item,
    output logic                   q_pop,
    output logic                   res_valid,
    output ntm_pkg::out_item_t     res_item,
    input  wire logic              res_pop
);

    localparam int AW = ntm_pkg::ADDR_W;
    localparam int CW = ntm_pkg::COUNT_W;
    localparam int SW = ntm_pkg::STAMP_W;

    ntm_pkg::back_state_t    state_reg, state_next;

    logic [CW-1:0]           count_reg;
    logic                    overflow_reg;
    logic                    res_valid_reg;
    logic [CW-1:0]           issue_idx_reg;
    logic                    rd_valid_reg;
    logic                    d_valid_reg;
    logic                    best_valid_reg;

    logic [SW-1:0]           ref_reg;
    logic [AW-1:0]           rd_idx_reg;
    logic [SW-1:0]           d_reg;
    logic [AW-1:0]           d_idx_reg;
    logic [SW-1:0]           d_stamp_reg;
    logic [AW-1:0]           best_idx_reg;
    logic [SW-1:0]           best_stamp_reg;
    logic [SW-1:0]           best_dist_reg;
    ntm_pkg::out_item_t      res_item_reg;

    logic                    do_clear;
    logic                    do_append;
    logic                    start;
    logic                    issue_en;
    logic                    take;
    logic                    finish;
    logic                    table_full;
    logic                    last_entry;
    logic [SW-1:0]           rdata;
    logic [AW-1:0]           sel_idx;
    logic [SW-1:0]           sel_stamp;
    logic [SW-1:0]           sel_dist;

    function automatic logic [SW-1:0] abs_diff(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign table_full = (count_reg >= CW'(ntm_pkg::TABLE_DEPTH));
    assign last_entry = ((CW'(d_idx_reg) + CW'(1)) == count_reg);

    ntm_ram #(
        .WIDTH (SW),
        .DEPTH (ntm_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (do_append && !table_full),
        .waddr (count_reg[AW-1:0]),
        .wdata (q_item.stamp),
        .raddr (issue_idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ntm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ntm_pkg::ST_SCAN;
                end
            end
            ntm_pkg::ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ntm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ntm_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop     = 1'b0;
        do_clear  = 1'b0;
        do_append = 1'b0;
        start     = 1'b0;
        issue_en  = 1'b0;
        take      = 1'b0;
        finish    = 1'b0;
        unique case (state_reg)
            ntm_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.command)
                        ntm_pkg::CMD_CLEAR:
                        begin
                            q_pop    = 1'b1;
                            do_clear = 1'b1;
                        end
                        ntm_pkg::CMD_APPEND:
                        begin
                            q_pop     = 1'b1;
                            do_append = 1'b1;
                        end
                        ntm_pkg::CMD_QUERY:
                        begin
                            // empty table: drop the query with no result
                            if (count_reg == '0)
                            begin
                                q_pop = 1'b1;
                            end
                            else if (!res_valid_reg)
                            begin
                                q_pop = 1'b1;
                                start = 1'b1;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ntm_pkg::ST_SCAN:
            begin
                issue_en = (issue_idx_reg < count_reg);
                if (d_valid_reg)
                begin
                    // ties move the best entry forward
                    take   = !best_valid_reg || (d_reg <= best_dist_reg);
                    finish = !take || last_entry;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sel_idx   = take ? d_idx_reg   : best_idx_reg;
    assign sel_stamp = take ? d_stamp_reg : best_stamp_reg;
    assign sel_dist  = take ? d_reg       : best_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ntm_pkg::ST_IDLE;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            issue_idx_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            d_valid_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (do_clear)
            begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else if (do_append)
            begin
                if (table_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (finish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end

            if (start)
            begin
                issue_idx_reg <= '0;
            end
            else if (issue_en)
            begin
                issue_idx_reg <= issue_idx_reg + 1'b1;
            end

            // flush reads in flight once the scan is over
            rd_valid_reg <= issue_en && !finish;
            d_valid_reg  <= rd_valid_reg && !finish;

            if (start)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (take)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ref_reg <= q_item.stamp;
        end
        if (issue_en)
        begin
            rd_idx_reg <= issue_idx_reg[AW-1:0];
        end
        if (rd_valid_reg)
        begin
            d_reg       <= abs_diff(rdata, ref_reg);
            d_idx_reg   <= rd_idx_reg;
            d_stamp_reg <= rdata;
        end
        if (take)
        begin
            best_idx_reg   <= d_idx_reg;
            best_stamp_reg <= d_stamp_reg;
            best_dist_reg  <= d_reg;
        end
        if (finish)
        begin
            res_item_reg.match_index    <= ntm_pkg::INDEX_W'(sel_idx);
            res_item_reg.match_stamp    <= sel_stamp;
            res_item_reg.match_distance <= sel_dist;
            res_item_reg.overflow       <= overflow_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

>>> rtl/nearest_timestamp_match_core.sv
// Beats are registered in the input queue before heading it; clear, append and
// empty-table queries retire on heading it while idle, unused codes drop at the input,
// and a query result is registered as its scan ends; the scan reads one table entry
// per cycle, up to TABLE_DEPTH, ending at the last entry or a rising distance. One beat
// per cycle enters the 4-deep queue unless full; one query scans at a time; a waiting
// result holds the next. Reset clears queues, count and overflow, not the table.
`default_nettype none

module nearest_timestamp_match_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ntm_pkg::in_item_t in_item,
    output logic                   empty,
    input  wire logic              pop,
    output ntm_pkg::out_item_t     out_item
);

    logic                q_valid;
    ntm_pkg::in_item_t   q_item;
    logic                q_pop;
    logic                res_valid;

    ntm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    ntm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_item  (out_item),
        .res_pop   (pop && res_valid)
    );

    assign empty = !res_valid;

endmodule

`default_nettype wire

>>> rtl/ntm_checker.sv
// Port-level checks for nearest_timestamp_match_core, attached by bind.
// Depends on ntm_pkg.
`default_nettype none

module ntm_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire ntm_pkg::in_item_t  in_item,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire ntm_pkg::out_item_t out_item
);

    // both queues come out of reset drained
    a_reset_drained: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queues not drained in reset");

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result beat changed while stalled");

    // a new scan starts only after the result slot frees
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> empty ##1 empty ##1 empty)
        else $error("result appeared too soon after pop");

    // the input queue fills only on a queued command beat
    a_full_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && (in_item.command != ntm_pkg::CMD_NOP)))
        else $error("input queue filled without a command beat");

endmodule

bind nearest_timestamp_match_core ntm_checker u_ntm_checker (.*);

`default_nettype wire

>>> tb/sv/nearest_timestamp_match_core_test.sv
// Testbench for nearest_timestamp_match_core: sends clear, append and query beats
// through the input queue and checks each match against a shadow copy of the table.
// Depends on ntm_pkg and the core RTL.

module nearest_timestamp_match_core_test;

    localparam int CLK_HALF     = 5;
    localparam int IDLE_LIMIT   = 8000;
    localparam int DRAIN_CYCLES = ntm_pkg::TABLE_DEPTH + 64;
    localparam int RANDOM_BEATS = 120;
    localparam int SW           = ntm_pkg::STAMP_W;
    localparam int AW           = ntm_pkg::ADDR_W;
    localparam logic [SW-1:0] STAMP_MAX = '1;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               push    = 1'b0;
    logic               pop     = 1'b0;
    ntm_pkg::in_item_t  in_item = '0;
    logic               full;
    logic               empty;
    ntm_pkg::out_item_t out_item;

    // shadow of the block's table
    logic [SW-1:0]      shadow_stamps [ntm_pkg::TABLE_DEPTH];
    int                 shadow_count    = 0;
    logic               shadow_overflow = 1'b0;
    ntm_pkg::out_item_t pending_matches [$];

    int fail_count    = 0;
    int beats_sent    = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int pop_mode      = 0;
    int pop_mode_left = 0;

    nearest_timestamp_match_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    always #CLK_HALF clk = ~clk;

    // Update the shadow table and queue the match a query should produce.
    task automatic apply_to_table(input ntm_pkg::in_item_t beat);
        logic [63:0]        best_dist;
        logic [63:0]        diff;
        logic [63:0]        entry;
        logic [63:0]        query_ref;
        int                 best;
        int                 k;
        bit                 stop;
        ntm_pkg::out_item_t match;
        case (beat.command)
            ntm_pkg::CMD_CLEAR:
            begin
                shadow_count    = 0;
                shadow_overflow = 1'b0;
            end
            ntm_pkg::CMD_APPEND:
            begin
                if (shadow_count < ntm_pkg::TABLE_DEPTH)
                begin
                    shadow_stamps[AW'(shadow_count)] = beat.stamp;
                    shadow_count++;
                end
                else
                begin
                    shadow_overflow = 1'b1;
                end
            end
            ntm_pkg::CMD_QUERY:
            begin
                if (shadow_count != 0)
                begin
                    best_dist = '1;
                    best      = 0;
                    stop      = 1'b0;
                    query_ref = {1'b0, beat.stamp};
                    // ties move to the later entry; stop once the distance rises
                    for (k = 0; k < shadow_count && !stop; k++)
                    begin
                        entry = {1'b0, shadow_stamps[AW'(k)]};
                        diff  = (entry > query_ref) ? entry - query_ref : query_ref - entry;
                        if (diff <= best_dist)
                        begin
                            best_dist = diff;
                            best      = k;
                        end
                        else
                        begin
                            stop = 1'b1;
                        end
                    end
                    match.match_index    = best[ntm_pkg::INDEX_W-1:0];
                    match.match_stamp    = shadow_stamps[AW'(best)];
                    match.match_distance = best_dist[SW-1:0];
                    match.overflow       = shadow_overflow;
                    pending_matches      = {pending_matches, match};
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Send one beat, then idle between bursts.
    task automatic send_beat(input ntm_pkg::cmd_t cmd, input logic [SW-1:0] stamp);
        ntm_pkg::in_item_t beat;
        int                gap;
        beat.command = cmd;
        beat.stamp   = stamp;
        push    <= 1'b1;
        in_item <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_to_table(beat);
        if (cmd != ntm_pkg::CMD_NOP)
            beats_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender until every pending match has been popped.
    task automatic wait_for_matches();
        push <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SW-1:0] random_stamp();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[SW-1:0];
    endfunction

    // Aim queries at stored entries, their neighbors and midpoints, or at random or extreme stamps.
    function automatic logic [SW-1:0] query_stamp();
        int            pick;
        logic [SW-1:0] a;
        logic [SW-1:0] b;
        logic [63:0]   mid;
        if (shadow_count == 0)
            return random_stamp();
        pick = $urandom_range(0, shadow_count - 1);
        a    = shadow_stamps[AW'(pick)];
        b    = shadow_stamps[AW'((pick + 1) % shadow_count)];
        mid  = ({1'b0, a} + {1'b0, b}) >> 1;
        case ($urandom_range(0, 5))
            0:       return a;
            1:       return a + SW'($urandom_range(0, 16));
            2:       return a - SW'($urandom_range(0, 16));
            3:       return mid[SW-1:0];
            4:       return random_stamp();
            default: return $urandom_range(0, 1) ? STAMP_MAX : '0;
        endcase
    endfunction

    task automatic fill_table(input int n_entries);
        int            style;
        int            k;
        logic [SW-1:0] s;
        style = $urandom_range(0, 3);
        s     = random_stamp();
        for (k = 0; k < n_entries; k++)
        begin
            case (style)
                0:       s = s + SW'($urandom_range(0, 40));
                1:       s = s - SW'($urandom_range(0, 40));
                2:       s = random_stamp();
                default: s = SW'($urandom_range(0, 15));
            endcase
            send_beat(ntm_pkg::CMD_APPEND, s);
        end
    endtask

    task automatic test_empty_and_ignored();
        send_beat(ntm_pkg::CMD_QUERY, '0);
        send_beat(ntm_pkg::CMD_NOP, STAMP_MAX);
        send_beat(ntm_pkg::CMD_CLEAR, STAMP_MAX);
        send_beat(ntm_pkg::CMD_QUERY, STAMP_MAX);
        send_beat(ntm_pkg::CMD_APPEND, 63'd77);
        send_beat(ntm_pkg::CMD_NOP, 63'd5);
        send_beat(ntm_pkg::CMD_QUERY, 63'd5);
    endtask

    task automatic test_extremes_and_ties();
        send_beat(ntm_pkg::CMD_CLEAR, '0);
        send_beat(ntm_pkg::CMD_APPEND, '0);
        send_beat(ntm_pkg::CMD_APPEND, STAMP_MAX);
        send_beat(ntm_pkg::CMD_QUERY, '0);
        send_beat(ntm_pkg::CMD_QUERY, STAMP_MAX);
        send_beat(ntm_pkg::CMD_QUERY, 63'h4000_0000_0000_0000);
        send_beat(ntm_pkg::CMD_NOP, 63'h2AAA_AAAA_AAAA_AAAA);
        send_beat(ntm_pkg::CMD_QUERY, 63'h2AAA_AAAA_AAAA_AAAA);
        // equal distances on both sides and a duplicate entry
        send_beat(ntm_pkg::CMD_CLEAR, '0);
        send_beat(ntm_pkg::CMD_APPEND, 63'd100);
        send_beat(ntm_pkg::CMD_APPEND, 63'd300);
        send_beat(ntm_pkg::CMD_APPEND, 63'd300);
        send_beat(ntm_pkg::CMD_APPEND, 63'd500);
        send_beat(ntm_pkg::CMD_QUERY, 63'd200);
        send_beat(ntm_pkg::CMD_QUERY, 63'd600);
        send_beat(ntm_pkg::CMD_QUERY, 63'd50);
        send_beat(ntm_pkg::CMD_QUERY, 63'd400);
        send_beat(ntm_pkg::CMD_APPEND, 63'h5555_5555_5555_5555);
        send_beat(ntm_pkg::CMD_QUERY, 63'h5555_5555_5555_5555);
        send_beat(ntm_pkg::CMD_QUERY, 63'd300);
    endtask

    task automatic test_full_table();
        logic [SW-1:0] s;
        int            k;
        send_beat(ntm_pkg::CMD_CLEAR, '0);
        // ascending stamps ending near the top of the range
        s = STAMP_MAX - (63'd1024 << 20) - SW'($urandom_range(0, 1000));
        for (k = 0; k < ntm_pkg::TABLE_DEPTH; k++)
        begin
            s = s + SW'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 1 << 20));
            send_beat(ntm_pkg::CMD_APPEND, s);
        end
        send_beat(ntm_pkg::CMD_QUERY, STAMP_MAX);
        send_beat(ntm_pkg::CMD_QUERY, '0);
        send_beat(ntm_pkg::CMD_QUERY, shadow_stamps[AW'(ntm_pkg::TABLE_DEPTH / 2)] + SW'(1));
        // drop appends past capacity
        repeat (3) send_beat(ntm_pkg::CMD_APPEND, random_stamp());
        send_beat(ntm_pkg::CMD_QUERY, STAMP_MAX);
        send_beat(ntm_pkg::CMD_QUERY, shadow_stamps[AW'(3)]);
        send_beat(ntm_pkg::CMD_CLEAR, '0);
        send_beat(ntm_pkg::CMD_APPEND, 63'd9);
        send_beat(ntm_pkg::CMD_QUERY, 63'd12);
    endtask

    task automatic test_random_traffic();
        int first_beat;
        int n_entries;
        int n_queries;
        bit paused;
        first_beat = beats_sent;
        paused     = 1'b0;
        while (beats_sent < first_beat + RANDOM_BEATS)
        begin
            if (!paused && beats_sent >= first_beat + RANDOM_BEATS / 2)
            begin
                wait_for_matches();
                paused = 1'b1;
            end
            if ($urandom_range(0, 6) != 0)
            begin
                send_beat(ntm_pkg::CMD_CLEAR, random_stamp());
                n_entries = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                        : $urandom_range(1, 12);
                fill_table(n_entries);
                n_queries = $urandom_range(1, 6);
                repeat (n_queries)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_beat(ntm_pkg::CMD_NOP, random_stamp());
                    send_beat(ntm_pkg::CMD_QUERY, query_stamp());
                end
            end
            else
            begin
                send_beat(ntm_pkg::cmd_t'(2'($urandom_range(0, 3))), random_stamp());
            end
        end
    endtask

    // Receiver stall pattern: switch at random among four pop modes.
    always @(posedge clk)
    begin
        if (pop_mode_left == 0)
        begin
            pop_mode      = $urandom_range(0, 3);
            pop_mode_left = $urandom_range(40, 300);
        end
        else
        begin
            pop_mode_left--;
        end
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 3) != 0);
            default: pop <= ($urandom_range(0, 24) == 0);
        endcase
    end

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : match_check
        ntm_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_matches.size() == 0)
            begin
                $display("%0t: match with nothing pending: expected none got index %0d stamp %h",
                         $time, out_item.match_index, out_item.match_stamp);
                fail_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                report_field("match_index", 64'(want.match_index),
                             64'(out_item.match_index));
                report_field("match_stamp", 64'(want.match_stamp),
                             64'(out_item.match_stamp));
                report_field("match_distance", 64'(want.match_distance),
                             64'(out_item.match_distance));
                report_field("overflow", 64'(want.overflow), 64'(out_item.overflow));
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_ignored();
        test_extremes_and_ties();
        test_full_table();
        test_random_traffic();
        wait_for_matches();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
